@@ hdl/kmp_pkg.sv @@
package kmp_pkg;

  localparam int MAX_PATTERN   = 16;
  localparam int POSITION_BITS = 32;
  localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W         = $clog2(MAX_PATTERN);
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int OFFSET_W      = 32;
  localparam int COUNT_W       = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_LOAD,
    ST_BUILD_CMP,
    ST_MATCH_STEP,
    ST_MATCH_FIN
  } kmp_state_e;

  typedef struct packed {
    logic build_init;
    logic build_load;
    logic build_fall;
    logic build_store;
    logic accept;
    logic match_fall;
    logic match_adv;
    logic emit;
    logic emit_hit;
  } kmp_cmd_t;

  typedef struct packed {
    logic cfg_write;
    logic build_done;
    logic build_mismatch;
    logic match_mismatch;
    logic match_hit;
    logic out_free;
  } kmp_status_t;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

endpackage

@@ hdl/kmp_text_if.sv @@
interface kmp_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       start_of_text;

  modport source (output valid, output text_byte, output start_of_text, input ready);
  modport sink   (input valid, input text_byte, input start_of_text, output ready);
endinterface

@@ hdl/kmp_result_if.sv @@
interface kmp_result_if import kmp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                match_found;
  logic [OFFSET_W-1:0] match_offset;
  logic [COUNT_W-1:0]  match_count;

  modport source (output valid, output match_found, output match_offset,
                  output match_count, input ready);
  modport sink   (input valid, input match_found, input match_offset,
                  input match_count, output ready);
endinterface

@@ hdl/kmp_ctrl.sv @@
module kmp_ctrl import kmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  kmp_status_t status_i,
  output kmp_cmd_t    cmd_o
);

  kmp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    if (status_i.cfg_write) begin
      state_d = ST_BUILD_LOAD;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_d = ST_MATCH_STEP;
        end
        ST_BUILD_LOAD: begin
          state_d = status_i.build_done ? ST_IDLE : ST_BUILD_CMP;
        end
        ST_BUILD_CMP: begin
          if (!status_i.build_mismatch) state_d = ST_BUILD_LOAD;
        end
        ST_MATCH_STEP: begin
          if (!status_i.match_mismatch) begin
            if (status_i.match_hit) state_d = ST_MATCH_FIN;
            else if (status_i.out_free) state_d = ST_IDLE;
          end
        end
        ST_MATCH_FIN: begin
          if (status_i.out_free) state_d = ST_IDLE;
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE) && !status_i.cfg_write;
    if (status_i.cfg_write) begin
      cmd_o.build_init = 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          cmd_o.accept = in_valid_i;
        end
        ST_BUILD_LOAD: begin
          cmd_o.build_load = 1'b1;
        end
        ST_BUILD_CMP: begin
          if (status_i.build_mismatch) cmd_o.build_fall = 1'b1;
          else cmd_o.build_store = 1'b1;
        end
        ST_MATCH_STEP: begin
          if (status_i.match_mismatch) cmd_o.match_fall = 1'b1;
          else if (status_i.match_hit) cmd_o.match_adv = 1'b1;
          else cmd_o.emit = status_i.out_free;
        end
        ST_MATCH_FIN: begin
          cmd_o.emit     = status_i.out_free;
          cmd_o.emit_hit = status_i.out_free;
        end
        default: cmd_o = '0;
      endcase
    end
  end

endmodule

@@ hdl/kmp_datapath.sv @@
module kmp_datapath import kmp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 start_of_text_i,
  input  kmp_cmd_t             cmd_i,
  output kmp_status_t          status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 match_found_o,
  output logic [OFFSET_W-1:0]  match_offset_o,
  output logic [COUNT_W-1:0]   match_count_o
);

  logic [CFG_W-1:0]         pat_lo_q, pat_hi_q;
  logic [4:0]               len_raw_q;
  logic [LEN_W-1:0]         fail_q [MAX_PATTERN];
  logic [LEN_W-1:0]         idx_q;    // matched prefix, also k while building
  logic [LEN_W-1:0]         qb_q;     // table entry under construction
  logic [7:0]               cur_q;    // folded pattern byte at qb_q
  logic [7:0]               char_q;   // folded text byte
  logic [POSITION_BITS-1:0] pos_q;
  logic [COUNT_W-1:0]       cnt_q;
  logic                     out_valid_q, out_found_q;
  logic [OFFSET_W-1:0]      out_offset_q;
  logic [COUNT_W-1:0]       out_count_q;

  logic [LEN_W-1:0]         len_eff;
  logic [2*CFG_W-1:0]       pat_word;
  logic [IDX_W-1:0]         pat_addr, fail_addr;
  logic [7:0]               pat_rd;
  logic [LEN_W-1:0]         fail_rd;
  logic                     eq_build, eq_match;
  logic [LEN_W-1:0]         k_next, q_next;
  logic [POSITION_BITS-1:0] offset_full;
  logic                     out_free;

  // Clamp length to 1..MAX_PATTERN
  always_comb begin
    if (len_raw_q == 5'd0) len_eff = LEN_W'(1);
    else if (32'(len_raw_q) > MAX_PATTERN) len_eff = LEN_W'(MAX_PATTERN);
    else len_eff = LEN_W'(len_raw_q);
  end

  assign pat_word  = {pat_hi_q, pat_lo_q};
  assign pat_addr  = cmd_i.build_load ? IDX_W'(qb_q) : IDX_W'(idx_q);
  assign pat_rd    = fold_case(pat_word[{pat_addr, 3'b000} +: 8]);
  assign fail_addr = IDX_W'(idx_q - LEN_W'(1));
  assign fail_rd   = fail_q[fail_addr];

  assign eq_build = (pat_rd == cur_q);
  assign eq_match = (pat_rd == char_q);
  assign k_next   = idx_q + LEN_W'(eq_build);
  assign q_next   = idx_q + LEN_W'(eq_match);

  assign offset_full = pos_q - POSITION_BITS'(len_eff) + POSITION_BITS'(1);
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    status_o                = '0;
    status_o.cfg_write      = cfg_we_i && (cfg_idx_i == CFG_PAT_LOW ||
                                           cfg_idx_i == CFG_PAT_HIGH ||
                                           cfg_idx_i == CFG_PAT_LEN);
    status_o.build_done     = (qb_q >= len_eff);
    status_o.build_mismatch = (idx_q != '0) && !eq_build;
    status_o.match_mismatch = (idx_q != '0) && !eq_match;
    status_o.match_hit      = (q_next == len_eff);
    status_o.out_free       = out_free;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      len_raw_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAT_LOW:  pat_lo_q  <= cfg_data_i;
        CFG_PAT_HIGH: pat_hi_q  <= cfg_data_i;
        CFG_PAT_LEN:  len_raw_q <= cfg_data_i[4:0];
        default:      ;
      endcase
    end
  end

  // Failure table; entry 0 is always zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PATTERN; i++) fail_q[i] <= '0;
    end else if (cmd_i.build_store) begin
      fail_q[IDX_W'(qb_q)] <= k_next;
    end
  end

  // Match / build state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      qb_q  <= LEN_W'(1);
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.build_init) begin
        idx_q <= '0;
        qb_q  <= LEN_W'(1);
      end
      if (cmd_i.build_fall || cmd_i.match_fall) idx_q <= fail_rd;
      if (cmd_i.build_store) begin
        idx_q <= k_next;
        qb_q  <= qb_q + LEN_W'(1);
      end
      // Table complete: matching restarts from an empty prefix
      if (cmd_i.build_load && qb_q >= len_eff) idx_q <= '0;
      if (cmd_i.accept && start_of_text_i) begin
        idx_q <= '0;
        pos_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.match_adv) idx_q <= q_next;
      if (cmd_i.emit) begin
        pos_q <= pos_q + POSITION_BITS'(1);
        if (cmd_i.emit_hit) begin
          idx_q <= fail_rd;
          if (cnt_q != '1) cnt_q <= cnt_q + COUNT_W'(1);
        end else begin
          idx_q <= q_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_load) cur_q <= pat_rd;
    if (cmd_i.accept) char_q <= fold_case(text_byte_i);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_found_q  <= cmd_i.emit_hit;
      out_offset_q <= cmd_i.emit_hit ? OFFSET_W'(offset_full) : '0;
      out_count_q  <= (cmd_i.emit_hit && cnt_q != '1) ? cnt_q + COUNT_W'(1) : cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_found_o  = out_found_q;
  assign match_offset_o = out_offset_q;
  assign match_count_o  = out_count_q;

endmodule

@@ hdl/kmp_stream_matcher_top.sv @@
// Streaming KMP matcher with ASCII case folding.
// text_i   : sink channel, one word per text byte (text_byte, start_of_text).
//            start_of_text clears match state, position and count first.
// result_o : source channel, one word per text byte: match_found, the start
//            offset of the match (0 when none) and the saturating match count.
// cfg_*    : write port. Index 0/1 pattern bytes 0-7 / 8-15, index 2 length.
//            A write to index 0..2 rebuilds the failure table and clears the
//            matched prefix; text_i.ready is low in the write cycle and during
//            the rebuild (load and compare steps, one more compare per fallback).
// Per word: an accept step, then a compare step in the matcher
// (each fallback through the failure table costs one more), plus a final
// step when the pattern completes; emitting waits for a free output register.
// The result sits in the output register the cycle after it is formed.
// The sequencer handles one word at a time; the single-ported pattern and
// failure-table reads set the step count.
// A stalled receiver holds the result register; the next word is accepted
// and processed meanwhile, and waits for the register to free up.
// Reset (async, active low) loads an all-zero pattern of length 1 with a
// zeroed table, clears position and count, and leaves the block ready.
module kmp_stream_matcher_top import kmp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  kmp_text_if.sink             text_i,
  kmp_result_if.source         result_o
);

  kmp_cmd_t    cmd;
  kmp_status_t status;

  // Sequencer: table build and per-byte match steps
  kmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (text_i.valid),
    .in_ready_o (text_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Pattern, failure table, counters and result register
  kmp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .text_byte_i     (text_i.text_byte),
    .start_of_text_i (text_i.start_of_text),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (result_o.ready),
    .out_valid_o     (result_o.valid),
    .match_found_o   (result_o.match_found),
    .match_offset_o  (result_o.match_offset),
    .match_count_o   (result_o.match_count)
  );

endmodule

@@ test/tb.sv @@
module tb;
  import kmp_pkg::*;

  // Index 3 of the write port is decoded by nobody; a write there must be a no-op.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_of_text;
  } text_word_t;

  typedef struct packed {
    logic                match_found;
    logic [OFFSET_W-1:0] match_offset;
    logic [COUNT_W-1:0]  match_count;
  } match_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = CFG_PAT_LOW;
  logic [CFG_W-1:0]     cfg_data   = '0;

  kmp_text_if   text_ch ();
  kmp_result_if result_ch ();

  kmp_stream_matcher_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .text_i     (text_ch),
    .result_o   (result_ch)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the matcher: configuration registers, folded pattern, failure
  // table, matched prefix, text position and saturating match count.
  // ---------------------------------------------------------------------------
  logic [63:0]         pat_low_q;
  logic [63:0]         pat_high_q;
  logic [4:0]          pat_len_q;
  logic [7:0]          pat_fold [MAX_PATTERN];
  int                  fail_tab [MAX_PATTERN];
  int                  pat_len;
  int                  prefix_len;
  logic [31:0]         text_pos;
  logic [COUNT_W-1:0]  found_total;

  text_word_t  pending_text [$];     // words waiting for the driver
  match_word_t expected_matches [$]; // predicted results, oldest first
  int          mismatches = 0;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  // Effective length is clamped to 1..MAX_PATTERN; the table is the usual
  // longest proper border of each pattern prefix.
  function automatic void rebuild_failure_table();
    int n, k, q;
    n = pat_len_q;
    if (n == 0) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    pat_len = n;
    for (q = 0; q < MAX_PATTERN; q++) begin
      pat_fold[q] = to_lower(q < 8 ? pat_low_q[8*q +: 8] : pat_high_q[8*(q-8) +: 8]);
      fail_tab[q] = 0;
    end
    k = 0;
    for (q = 1; q < n; q++) begin
      while (k > 0 && pat_fold[k] != pat_fold[q]) k = fail_tab[k-1];
      if (pat_fold[k] == pat_fold[q]) k++;
      fail_tab[q] = k;
    end
    prefix_len = 0;
  endfunction

  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
    case (idx)
      CFG_PAT_LOW:  pat_low_q  = data;
      CFG_PAT_HIGH: pat_high_q = data;
      CFG_PAT_LEN:  pat_len_q  = data[4:0];
      default:      return;
    endcase
    rebuild_failure_table();
  endfunction

  function automatic void predict_match(input text_word_t w);
    logic [7:0]  c;
    int          q;
    match_word_t r;
    c = to_lower(w.text_byte);
    if (w.start_of_text) begin
      prefix_len  = 0;
      text_pos    = '0;
      found_total = '0;
    end
    q = prefix_len;
    if (q >= pat_len) q = 0;
    while (q > 0 && pat_fold[q] != c) q = fail_tab[q-1];
    if (pat_fold[q] == c) q++;
    r = '0;
    if (q == pat_len) begin
      // Pattern ends here; fall back so overlapping matches are found.
      r.match_found  = 1'b1;
      r.match_offset = text_pos - 32'(pat_len) + 32'd1;
      if (found_total != '1) found_total = found_total + 1'b1;
      q = fail_tab[q-1];
    end
    r.match_count = found_total;
    prefix_len    = q;
    text_pos      = text_pos + 32'd1;
    expected_matches = {expected_matches, r};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ERROR %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The slowest legal run ends well before this watchdog fires.
  initial begin
    #(20 * 600000);
    $display("kmp_stream_matcher_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers words from pending_text in bursts of random length with
  // random gaps; a word stays on the bus until it is taken. Accepted words go
  // straight into the predictor.
  // ---------------------------------------------------------------------------
  text_word_t cur_word = '0;
  int         burst_left = 0;
  int         gap_left   = 0;
  logic       offer;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      text_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (text_ch.valid && text_ch.ready) predict_match(cur_word);
      offer = text_ch.valid && !text_ch.ready;
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_text.size() != 0) begin
          cur_word = pending_text.pop_front();
          offer    = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          // Back-to-back bursts a third of the time, so long runs go unbroken.
          if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      text_ch.valid         <= offer;
      text_ch.text_byte     <= cur_word.text_byte;
      text_ch.start_of_text <= cur_word.start_of_text;
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off, counted here. Armed once by the stimulus while a
  // big batch is being offered, so the matcher backs up into its input.
  // ---------------------------------------------------------------------------
  logic hold_arm  = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every taken result word against the oldest prediction.
  // Ready follows a pattern that switches at random between always
  // ready, coin toss, mostly stalled and a square wave.
  // ---------------------------------------------------------------------------
  int          sink_mode  = 0;
  int          sink_cycle = 0;
  logic        sink_ready;
  match_word_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_matches.size() == 0) begin
          report_mismatch("result with nothing outstanding", result_ch.match_offset, '0);
        end else begin
          want = expected_matches.pop_front();
          if (result_ch.match_found !== want.match_found)
            report_mismatch("match_found", 32'(result_ch.match_found), 32'(want.match_found));
          if (result_ch.match_offset !== want.match_offset)
            report_mismatch("match_offset", result_ch.match_offset, want.match_offset);
          if (result_ch.match_count !== want.match_count)
            report_mismatch("match_count", result_ch.match_count, want.match_count);
        end
      end
      sink_cycle++;
      if (sink_cycle % 50 == 0) sink_mode = $urandom_range(0, 3);
      case (sink_mode)
        0:       sink_ready = 1'b1;
        1:       sink_ready = $urandom_range(0, 1);
        2:       sink_ready = ($urandom_range(0, 3) == 0);
        default: sink_ready = sink_cycle[2];
      endcase
      result_ch.ready <= sink_ready && (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_word(input logic [7:0] b, input logic sot);
    text_word_t w;
    w.text_byte     = b;
    w.start_of_text = sot;
    pending_text = {pending_text, w};
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    if (l >= 8'h61 && l <= 8'h7A && $urandom_range(0, 1)) return c ^ 8'h20;
    return c;
  endfunction

  // Idle = nothing queued, nothing offered, nothing outstanding. Sampled on
  // the falling edge so the driver's updates at the rising edge have settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_text.size() != 0 || text_ch.valid || expected_matches.size() != 0)
      @(negedge clk_i);
  endtask

  // Write one register, then let the table rebuild finish (input ready again).
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    apply_config(idx, data);
    repeat (3) @(negedge clk_i);
    while (!text_ch.ready) @(negedge clk_i);
  endtask

  // Pattern over a tiny alphabet, often periodic so the failure table gets
  // deep borders; bytes past the length are junk that must not matter.
  task automatic load_random_pattern(input logic [4:0] len_raw);
    logic [7:0]  sym   [3];
    logic [7:0]  bytes [MAX_PATTERN];
    logic [63:0] lo, hi, len_data;
    int          motif, q;
    sym[0] = 8'h61;
    sym[1] = 8'h62;
    sym[2] = 8'($urandom);
    motif  = $urandom_range(0, 3);
    for (q = 0; q < MAX_PATTERN; q++) begin
      if (motif != 0 && q >= motif) bytes[q] = bytes[q-motif];
      else bytes[q] = sym[$urandom_range(0, 2)];
      if ($urandom_range(0, 7) == 0) bytes[q] = 8'($urandom);
    end
    for (q = 0; q < MAX_PATTERN; q++) begin
      if (q < 8) lo[8*q +: 8] = flip_case(bytes[q]);
      else hi[8*(q-8) +: 8] = flip_case(bytes[q]);
    end
    // Upper data bits of the length write are don't-care; toggle them now and then.
    len_data = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) len_data = '0;
    len_data[4:0] = len_raw;
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_PAT_LOW, lo);
      write_reg(CFG_PAT_HIGH, hi);
      write_reg(CFG_PAT_LEN, len_data);
    end else begin
      write_reg(CFG_PAT_LEN, len_data);
      write_reg(CFG_PAT_HIGH, hi);
      write_reg(CFG_PAT_LOW, lo);
    end
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
  endtask

  // Text mostly made of whole pattern copies (with random case), broken
  // prefixes and pattern letters, plus some raw bytes and the odd restart.
  function automatic void queue_text(input int n);
    int         left, k, pick, m;
    text_word_t w;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) m = pat_len;
      else if (pick < 65) m = $urandom_range(1, pat_len);
      else m = 1;
      if (m > left) m = left;
      for (k = 0; k < m; k++) begin
        w.start_of_text = ($urandom_range(0, 59) == 0);
        if (pick < 65) w.text_byte = flip_case(pat_fold[k]);
        else if (pick < 88) w.text_byte = flip_case(pat_fold[$urandom_range(0, pat_len - 1)]);
        else w.text_byte = 8'($urandom);
        pending_text = {pending_text, w};
        left--;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [4:0] phase_len  [10] = '{5'd16, 5'd5, 5'd1, 5'd9, 5'd0, 5'd24, 5'd3, 5'd16, 5'd31, 5'd2};
  int         phase_size [10] = '{60, 70, 60, 250, 50, 60, 70, 40, 60, 40};

  initial begin
    text_ch.valid         = 1'b0;
    text_ch.text_byte     = '0;
    text_ch.start_of_text = 1'b0;
    result_ch.ready       = 1'b0;
    rst_ni                = 1'b0;
    pat_low_q             = '0;
    pat_high_q            = '0;
    pat_len_q             = 5'd1;
    text_pos              = '0;
    found_total           = '0;
    rebuild_failure_table();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset pattern is a single NUL byte: only 0x00 hits.
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b1);
    push_word(8'h41, 1'b0);
    wait_drained();

    // "aBa", junk above: case folding, overlap, non-letters next to A-Z, restart.
    write_reg(CFG_PAT_LOW, 64'hFFFF_FFFF_FF61_4261);
    write_reg(CFG_PAT_HIGH, '1);
    write_reg(CFG_PAT_LEN, 64'd3);
    push_word(8'h41, 1'b0);
    push_word(8'h62, 1'b0);
    push_word(8'h41, 1'b0);
    push_word(8'h42, 1'b0);
    push_word(8'h61, 1'b0);
    push_word(8'h40, 1'b0);
    push_word(8'h5B, 1'b0);
    push_word(8'h61, 1'b1);
    push_word(8'h62, 1'b0);
    push_word(8'h61, 1'b0);
    wait_drained();

    // Length zero acts as one: pattern "a".
    write_reg(CFG_PAT_LEN, 64'd0);
    push_word(8'h5A, 1'b0);
    push_word(8'h41, 1'b0);
    wait_drained();
    // Unused index: nothing changes.
    write_reg(CFG_UNUSED, '1);
    push_word(8'h61, 1'b0);
    wait_drained();
    // Length past the maximum clamps to 16.
    write_reg(CFG_PAT_LEN, 64'd31);
    push_word(8'h7B, 1'b0);
    push_word(8'h60, 1'b0);
    wait_drained();

    // Random phases over a range of lengths, extremes included.
    for (int p = 0; p < 10; p++) begin
      load_random_pattern(phase_len[p]);
      queue_text(phase_size[p]);
      if (p == 3) hold_arm <= 1'b1;
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("kmp_stream_matcher_top: match");
    end else begin
      $display("kmp_stream_matcher_top: mismatch");
    end
    $finish;
  end

endmodule
